[sv/ddo_pkg.sv]
// ============================================================================
// ddo_pkg
// Shared constants, register indexes and the arctangent table used by the
// differential-drive odometry block.
// ============================================================================
package ddo_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WHEELS_EN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd7;

    localparam logic [63:0] W32_MAX = 64'h0000_0000_7FFF_FFFF;

    // atan(2^-i) scaled by 2^32
    function automatic logic [31:0] atan_q32(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'd3373259426;
                5'd1:  v = 32'd1991351318;
                5'd2:  v = 32'd1052175346;
                5'd3:  v = 32'd534100635;
                5'd4:  v = 32'd268086748;
                5'd5:  v = 32'd134174063;
                5'd6:  v = 32'd67103403;
                5'd7:  v = 32'd33553749;
                5'd8:  v = 32'd16777131;
                5'd9:  v = 32'd8388597;
                5'd10: v = 32'd4194303;
                5'd11: v = 32'd2097152;
                5'd12: v = 32'd1048576;
                5'd13: v = 32'd524288;
                5'd14: v = 32'd262144;
                5'd15: v = 32'd131072;
                5'd16: v = 32'd65536;
                5'd17: v = 32'd32768;
                5'd18: v = 32'd16384;
                5'd19: v = 32'd8192;
                5'd20: v = 32'd4096;
                5'd21: v = 32'd2048;
                5'd22: v = 32'd1024;
                5'd23: v = 32'd512;
                default: v = 32'd0;
            endcase
            atan_q32 = v;
        end
    endfunction

endpackage

[sv/diff_drive_odometry_top.sv]
// ============================================================================
// diff_drive_odometry_top
// Differential-drive kinematics and pose integration, bit-serial datapath.
// ============================================================================
// One item at a time. Every multiply and divide runs on one shared bit-serial
// unit: a multiply consumes one bit of a 32-bit operand per cycle, a divide
// produces one quotient bit of 64 per cycle; cos/sin come from CORDIC. A
// body-speed command is first turned into wheel speeds, and wheel speeds above
// the limit are scaled down on the unit. With wheels disabled an item skips
// the arithmetic and goes straight to the result. A start_heading write wraps
// the angle through the divider and keeps the block busy until the wrap is
// done. The result waits in an output register, so a new item is taken while
// the previous result is stalled.
module diff_drive_odometry_top #(
    parameter int FRAC_BITS       = 16,
    parameter int TRIG_ITERATIONS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic        kind,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [31:0] pos_x,
    output logic [31:0] pos_y,
    output logic [18:0] heading,
    output logic        speed_limited,
    output logic        moved,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import ddo_pkg::*;

    localparam int Q = FRAC_BITS;
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< Q;
    localparam logic signed [63:0] PI_Q =
        (64'sd13493037705 + (64'sd1 <<< (31 - Q))) >>> (32 - Q);
    localparam logic signed [63:0] GAIN_Q =
        (64'sd2608131496 + (64'sd1 <<< (31 - Q))) >>> (32 - Q);
    localparam logic signed [63:0] HALF_PI_Q = PI_Q / 2;
    localparam logic signed [63:0] TWO_PI_Q = 2 * PI_Q;
    localparam logic signed [63:0] TS_RST = (ONE_Q + 5) / 10;
    localparam logic [63:0] ATAN_RND = 64'd1 << (31 - Q);

    localparam logic signed [31:0] PI32   = PI_Q[31:0];
    localparam logic signed [31:0] HALF32 = HALF_PI_Q[31:0];
    localparam logic signed [31:0] GAIN32 = GAIN_Q[31:0];
    localparam logic [31:0]        TWO32  = TWO_PI_Q[31:0];
    localparam logic [4:0]         CORD_LAST = 5'(TRIG_ITERATIONS - 1);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_WB    = 5'd1;
    localparam logic [4:0] S_DIVL  = 5'd2;
    localparam logic [4:0] S_DIVR  = 5'd3;
    localparam logic [4:0] S_LIM   = 5'd4;
    localparam logic [4:0] S_SCL_M = 5'd5;
    localparam logic [4:0] S_SCL_D = 5'd6;
    localparam logic [4:0] S_SCR_M = 5'd7;
    localparam logic [4:0] S_SCR_D = 5'd8;
    localparam logic [4:0] S_SPD   = 5'd9;
    localparam logic [4:0] S_RTM   = 5'd10;
    localparam logic [4:0] S_RTD   = 5'd11;
    localparam logic [4:0] S_CORD  = 5'd12;
    localparam logic [4:0] S_VXM   = 5'd13;
    localparam logic [4:0] S_DXM   = 5'd14;
    localparam logic [4:0] S_VYM   = 5'd15;
    localparam logic [4:0] S_DYM   = 5'd16;
    localparam logic [4:0] S_DTH   = 5'd17;
    localparam logic [4:0] S_WRAP  = 5'd18;
    localparam logic [4:0] S_DONE  = 5'd19;

    function automatic logic signed [64:0] sx32(input logic signed [31:0] v);
        sx32 = {{33{v[31]}}, v};
    endfunction

    function automatic logic [63:0] mag65(input logic signed [64:0] v);
        logic signed [64:0] n;
        begin
            n = -v;
            mag65 = v[64] ? n[63:0] : v[63:0];
        end
    endfunction

    function automatic logic signed [31:0] sat_sym(input logic [63:0] m, input logic ng);
        logic [31:0] c;
        begin
            c = (m > W32_MAX) ? W32_MAX[31:0] : {1'b0, m[30:0]};
            sat_sym = ng ? -c : c;
        end
    endfunction

    function automatic logic signed [31:0] sat_full(input logic [63:0] m, input logic ng);
        logic [31:0] r;
        begin
            if (ng)
                r = (m >= 64'h8000_0000) ? 32'h8000_0000 : -m[31:0];
            else
                r = (m > W32_MAX) ? W32_MAX[31:0] : m[31:0];
            sat_full = r;
        end
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [64:0] s);
        logic signed [31:0] r;
        begin
            if (s > sx32(32'sh7FFF_FFFF))
                r = 32'sh7FFF_FFFF;
            else if (s < sx32(32'sh8000_0000))
                r = 32'sh8000_0000;
            else
                r = s[31:0];
            sat_add = r;
        end
    endfunction

    // configuration and pose
    logic [30:0]        rad_reg, ht_reg, lim_reg, dt_reg;
    logic               en_reg;
    logic signed [31:0] pose_x_reg, pose_y_reg, pose_h_reg;

    // sequencer
    logic [4:0]         state_reg;
    logic               run_reg, neg_reg, cfgw_reg, limited_reg, moved_reg;
    logic signed [31:0] a_reg, b_reg, lw_reg, rw_reg, spd_reg, rate_reg;
    logic signed [64:0] wb_reg, hw_reg;
    logic [63:0]        t_reg;
    logic [30:0]        m_reg;
    logic signed [33:0] vx_reg, vy_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic               fneg_reg;
    logic [4:0]         ci_reg;

    // output register
    logic               res_valid_reg, res_lim_reg, res_moved_reg;
    logic [31:0]        res_x_reg, res_y_reg;
    logic [18:0]        res_h_reg;
    logic               res_load;

    // serial multiply / divide unit
    logic               u_busy_reg, u_done_reg, u_div_reg;
    logic [5:0]         u_cnt_reg;
    logic [63:0]        u_a_reg, u_acc_reg;
    logic [31:0]        u_b_reg;
    logic [32:0]        u_rem_reg;
    logic [32:0]        u_rem_sh;
    logic               u_start, unit_st;

    logic [63:0]        op_a;
    logic [31:0]        op_b;
    logic               op_div, op_neg;

    logic [30:0]        r_eff, ht_eff, lim_eff;
    logic signed [64:0] num_l, num_r, sum_lr, dif_lr, tw;
    logic signed [31:0] cval, sval;
    logic [31:0]        cmag, smag;
    logic [31:0]        cstep;
    logic [30:0]        ml, mr, mx;
    logic [63:0]        pq_sh;
    logic signed [64:0] pq_s;
    logic [32:0]        wr;
    logic signed [64:0] hfix;
    logic [63:0]        vmag;
    logic signed [33:0] vsat;

    assign r_eff   = (rad_reg == '0) ? 31'd1 : rad_reg;
    assign ht_eff  = (ht_reg == '0) ? 31'd1 : ht_reg;
    assign lim_eff = (lim_reg == '0) ? 31'd1 : lim_reg;

    assign num_l  = (sx32(a_reg) <<< Q) + wb_reg;
    assign num_r  = (sx32(a_reg) <<< Q) - wb_reg;
    assign sum_lr = sx32(lw_reg) + sx32(rw_reg);
    assign dif_lr = sx32(lw_reg) - sx32(rw_reg);
    assign tw     = hw_reg + 65'(PI_Q);
    assign cval   = fneg_reg ? -cx_reg : cx_reg;
    assign sval   = fneg_reg ? -cy_reg : cy_reg;
    assign cmag   = cval[31] ? -cval : cval;
    assign smag   = sval[31] ? -sval : sval;
    assign cstep  = 32'(({32'd0, atan_q32(ci_reg)} + ATAN_RND) >> (32 - Q));

    assign ml = lw_reg[31] ? 31'(-lw_reg) : lw_reg[30:0];
    assign mr = rw_reg[31] ? 31'(-rw_reg) : rw_reg[30:0];
    assign mx = (ml > mr) ? ml : mr;

    assign pq_sh = u_acc_reg >> Q;
    assign pq_s  = neg_reg ? -{1'b0, pq_sh} : {1'b0, pq_sh};
    assign wr    = (u_rem_reg == '0) ? 33'd0 : {1'b0, TWO32} - u_rem_reg;
    assign hfix  = (neg_reg ? {32'd0, wr} : {32'd0, u_rem_reg}) - 65'(PI_Q);
    assign vmag  = (pq_sh > 64'h1_0000_0000) ? 64'h1_0000_0000 : pq_sh;
    assign vsat  = neg_reg ? -34'(vmag) : 34'(vmag);

    always_comb
    begin
        case (state_reg)
            S_WB, S_DIVL, S_DIVR, S_SCL_M, S_SCL_D, S_SCR_M, S_SCR_D, S_SPD,
            S_RTM, S_RTD, S_VXM, S_DXM, S_VYM, S_DYM, S_DTH, S_WRAP: unit_st = 1'b1;
            default: unit_st = 1'b0;
        endcase
    end

    assign u_start = unit_st && !run_reg;

    always_comb
    begin
        op_a   = '0;
        op_b   = '0;
        op_div = 1'b0;
        op_neg = 1'b0;
        case (state_reg)
            S_WB:
            begin
                op_a = mag65(sx32(b_reg)); op_b = {1'b0, ht_eff}; op_neg = b_reg[31];
            end
            S_DIVL:
            begin
                op_a = mag65(num_l); op_b = {1'b0, r_eff}; op_div = 1'b1;
                op_neg = num_l[64];
            end
            S_DIVR:
            begin
                op_a = mag65(num_r); op_b = {1'b0, r_eff}; op_div = 1'b1;
                op_neg = num_r[64];
            end
            S_SCL_M:
            begin
                op_a = mag65(sx32(lw_reg)); op_b = {1'b0, lim_eff}; op_neg = lw_reg[31];
            end
            S_SCL_D:
            begin
                op_a = t_reg; op_b = {1'b0, m_reg}; op_div = 1'b1; op_neg = lw_reg[31];
            end
            S_SCR_M:
            begin
                op_a = mag65(sx32(rw_reg)); op_b = {1'b0, lim_eff}; op_neg = rw_reg[31];
            end
            S_SCR_D:
            begin
                op_a = t_reg; op_b = {1'b0, m_reg}; op_div = 1'b1; op_neg = rw_reg[31];
            end
            S_SPD:
            begin
                op_a = mag65(sum_lr); op_b = {1'b0, r_eff}; op_neg = sum_lr[64];
            end
            S_RTM:
            begin
                op_a = mag65(dif_lr); op_b = {1'b0, r_eff}; op_neg = dif_lr[64];
            end
            S_RTD:
            begin
                op_a = t_reg; op_b = {ht_eff, 1'b0}; op_div = 1'b1; op_neg = dif_lr[64];
            end
            S_VXM:
            begin
                op_a = mag65(sx32(spd_reg)); op_b = cmag;
                op_neg = spd_reg[31] ^ cval[31];
            end
            S_DXM:
            begin
                op_a = mag65(65'(vx_reg)); op_b = {1'b0, dt_reg}; op_neg = vx_reg[33];
            end
            S_VYM:
            begin
                op_a = mag65(sx32(spd_reg)); op_b = smag;
                op_neg = spd_reg[31] ^ sval[31];
            end
            S_DYM:
            begin
                op_a = mag65(65'(vy_reg)); op_b = {1'b0, dt_reg}; op_neg = vy_reg[33];
            end
            S_DTH:
            begin
                op_a = mag65(sx32(rate_reg)); op_b = {1'b0, dt_reg}; op_neg = rate_reg[31];
            end
            S_WRAP:
            begin
                op_a = mag65(tw); op_b = TWO32; op_div = 1'b1; op_neg = tw[64];
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    // bit-serial unit: multiply consumes one bit of the 32-bit operand per cycle,
    // divide produces one quotient bit per cycle (restoring)
    assign u_rem_sh = {u_rem_reg[31:0], u_a_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_busy_reg <= 1'b0;
            u_done_reg <= 1'b0;
            u_div_reg  <= 1'b0;
            u_cnt_reg  <= '0;
            u_a_reg    <= '0;
            u_b_reg    <= '0;
            u_acc_reg  <= '0;
            u_rem_reg  <= '0;
        end
        else if (u_start)
        begin
            u_busy_reg <= 1'b1;
            u_done_reg <= 1'b0;
            u_div_reg  <= op_div;
            u_cnt_reg  <= '0;
            u_a_reg    <= op_a;
            u_b_reg    <= op_b;
            u_acc_reg  <= '0;
            u_rem_reg  <= '0;
        end
        else if (u_busy_reg)
        begin
            u_cnt_reg <= u_cnt_reg + 6'd1;
            if (u_div_reg)
            begin
                if (u_rem_sh >= {1'b0, u_b_reg})
                begin
                    u_rem_reg <= u_rem_sh - {1'b0, u_b_reg};
                    u_a_reg   <= {u_a_reg[62:0], 1'b1};
                end
                else
                begin
                    u_rem_reg <= u_rem_sh;
                    u_a_reg   <= {u_a_reg[62:0], 1'b0};
                end
            end
            else
            begin
                if (u_b_reg[0])
                    u_acc_reg <= u_acc_reg + u_a_reg;
                u_a_reg <= {u_a_reg[62:0], 1'b0};
                u_b_reg <= {1'b0, u_b_reg[31:1]};
            end
            if (u_cnt_reg == (u_div_reg ? 6'd63 : 6'd31))
            begin
                u_busy_reg <= 1'b0;
                u_done_reg <= 1'b1;
            end
        end
        else
        begin
            u_done_reg <= 1'b0;
        end
    end

    assign cmd_stall = (state_reg != S_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign res_load  = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg       <= ONE_Q[30:0];
            ht_reg        <= ONE_Q[30:0];
            lim_reg       <= ONE_Q[30:0];
            dt_reg        <= TS_RST[30:0];
            en_reg        <= 1'b0;
            pose_x_reg    <= '0;
            pose_y_reg    <= '0;
            pose_h_reg    <= '0;
            state_reg     <= S_IDLE;
            run_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            cfgw_reg      <= 1'b0;
            limited_reg   <= 1'b0;
            moved_reg     <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            lw_reg        <= '0;
            rw_reg        <= '0;
            spd_reg       <= '0;
            rate_reg      <= '0;
            wb_reg        <= '0;
            hw_reg        <= '0;
            t_reg         <= '0;
            m_reg         <= '0;
            vx_reg        <= '0;
            vy_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            cz_reg        <= '0;
            fneg_reg      <= 1'b0;
            ci_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_lim_reg   <= 1'b0;
            res_moved_reg <= 1'b0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_h_reg     <= '0;
        end
        else
        begin
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (res_valid_reg && !res_stall)
                res_valid_reg <= 1'b0;

            if (unit_st && !run_reg)
            begin
                run_reg <= 1'b1;
                neg_reg <= op_neg;
            end
            else if (unit_st && u_done_reg)
            begin
                run_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        case (cfg_index)
                            REG_WHEEL_RADIUS: rad_reg <= cfg_data[30:0];
                            REG_HALF_TRACK:   ht_reg  <= cfg_data[30:0];
                            REG_SPEED_LIMIT:  lim_reg <= cfg_data[30:0];
                            REG_TIME_STEP:    dt_reg  <= cfg_data[30:0];
                            REG_WHEELS_EN:    en_reg  <= cfg_data[0];
                            REG_START_X:      pose_x_reg <= cfg_data;
                            REG_START_Y:      pose_y_reg <= cfg_data;
                            REG_START_HEADING:
                            begin
                                hw_reg    <= {{46{cfg_data[18]}}, cfg_data[18:0]};
                                cfgw_reg  <= 1'b1;
                                state_reg <= S_WRAP;
                            end
                            default: en_reg <= en_reg;
                        endcase
                    end
                    else if (cmd_valid)
                    begin
                        a_reg       <= first_value;
                        b_reg       <= second_value;
                        limited_reg <= 1'b0;
                        moved_reg   <= en_reg;
                        cfgw_reg    <= 1'b0;
                        if (!en_reg)
                            state_reg <= S_DONE;
                        else if (kind)
                        begin
                            lw_reg <= (first_value == 32'h8000_0000) ?
                                      32'h8000_0001 : first_value;
                            rw_reg <= (second_value == 32'h8000_0000) ?
                                      32'h8000_0001 : second_value;
                            state_reg <= S_LIM;
                        end
                        else
                            state_reg <= S_WB;
                    end
                end
                S_WB:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        wb_reg    <= neg_reg ? -{1'b0, u_acc_reg} : {1'b0, u_acc_reg};
                        state_reg <= S_DIVL;
                    end
                end
                S_DIVL:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        lw_reg    <= sat_sym(u_a_reg, neg_reg);
                        state_reg <= S_DIVR;
                    end
                end
                S_DIVR:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        rw_reg    <= sat_sym(u_a_reg, neg_reg);
                        state_reg <= S_LIM;
                    end
                end
                S_LIM:
                begin
                    if (mx > lim_eff)
                    begin
                        m_reg       <= mx;
                        limited_reg <= 1'b1;
                        state_reg   <= S_SCL_M;
                    end
                    else
                        state_reg <= S_SPD;
                end
                S_SCL_M:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        t_reg     <= u_acc_reg;
                        state_reg <= S_SCL_D;
                    end
                end
                S_SCL_D:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        lw_reg    <= sat_sym(u_a_reg, neg_reg);
                        state_reg <= S_SCR_M;
                    end
                end
                S_SCR_M:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        t_reg     <= u_acc_reg;
                        state_reg <= S_SCR_D;
                    end
                end
                S_SCR_D:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        rw_reg    <= sat_sym(u_a_reg, neg_reg);
                        state_reg <= S_SPD;
                    end
                end
                S_SPD:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        spd_reg   <= sat_full(u_acc_reg >> (Q + 1), neg_reg);
                        state_reg <= S_RTM;
                    end
                end
                S_RTM:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        t_reg     <= u_acc_reg;
                        state_reg <= S_RTD;
                    end
                end
                S_RTD:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        rate_reg <= sat_full(u_a_reg, neg_reg);
                        cx_reg   <= GAIN32;
                        cy_reg   <= '0;
                        ci_reg   <= '0;
                        if (pose_h_reg > HALF32)
                        begin
                            cz_reg   <= pose_h_reg - PI32;
                            fneg_reg <= 1'b1;
                        end
                        else if (pose_h_reg < -HALF32)
                        begin
                            cz_reg   <= pose_h_reg + PI32;
                            fneg_reg <= 1'b1;
                        end
                        else
                        begin
                            cz_reg   <= pose_h_reg;
                            fneg_reg <= 1'b0;
                        end
                        state_reg <= S_CORD;
                    end
                end
                S_CORD:
                begin
                    if (!cz_reg[31])
                    begin
                        cx_reg <= cx_reg - (cy_reg >>> ci_reg);
                        cy_reg <= cy_reg + (cx_reg >>> ci_reg);
                        cz_reg <= cz_reg - cstep;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + (cy_reg >>> ci_reg);
                        cy_reg <= cy_reg - (cx_reg >>> ci_reg);
                        cz_reg <= cz_reg + cstep;
                    end
                    ci_reg <= ci_reg + 5'd1;
                    if (ci_reg == CORD_LAST)
                        state_reg <= S_VXM;
                end
                S_VXM:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        vx_reg    <= vsat;
                        state_reg <= S_DXM;
                    end
                end
                S_DXM:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        pose_x_reg <= sat_add(sx32(pose_x_reg) + pq_s);
                        state_reg  <= S_VYM;
                    end
                end
                S_VYM:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        vy_reg    <= vsat;
                        state_reg <= S_DYM;
                    end
                end
                S_DYM:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        pose_y_reg <= sat_add(sx32(pose_y_reg) + pq_s);
                        state_reg  <= S_DTH;
                    end
                end
                S_DTH:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        hw_reg    <= sx32(pose_h_reg) + pq_s;
                        state_reg <= S_WRAP;
                    end
                end
                S_WRAP:
                begin
                    if (run_reg && u_done_reg)
                    begin
                        pose_h_reg <= hfix[31:0];
                        state_reg  <= cfgw_reg ? S_IDLE : S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (res_load)
                    begin
                        res_x_reg     <= pose_x_reg;
                        res_y_reg     <= pose_y_reg;
                        res_h_reg     <= pose_h_reg[18:0];
                        res_lim_reg   <= limited_reg;
                        res_moved_reg <= moved_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res_valid     = res_valid_reg;
    assign pos_x         = res_x_reg;
    assign pos_y         = res_y_reg;
    assign heading       = res_h_reg;
    assign speed_limited = res_lim_reg;
    assign moved         = res_moved_reg;

endmodule

[sv/ddo_chk.sv]
// ============================================================================
// ddo_chk
// Port-level checks for the differential-drive odometry block.
// ============================================================================
module ddo_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_stall,
    input logic        res_valid,
    input logic        res_stall,
    input logic [31:0] pos_x,
    input logic        speed_limited,
    input logic        moved,
    input logic        cfg_ready
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> $stable(pos_x))
        else $error("stalled result changed");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall && !cfg_ready)
        else $error("block idle right after taking an item");

    a_limit_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !moved |-> !speed_limited)
        else $error("limit flagged on an item that did not move");

endmodule

bind diff_drive_odometry_top ddo_chk u_ddo_chk (.*);

[tb/diff_drive_odometry_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// diff_drive_odometry_checker
// Watches the command, result and register write channels of the odometry
// block. It keeps its own copy of the geometry registers and the pose, works
// out the pose update for each accepted command and compares each accepted
// result, field by field, with the oldest pending prediction.
// ============================================================================
module diff_drive_odometry_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  logic        cmd_stall,
    input  logic        kind,
    input  logic [31:0] first_value,
    input  logic [31:0] second_value,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [18:0] heading,
    input  logic        speed_limited,
    input  logic        moved,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          errors,
    output int          outstanding
);
    import ddo_pkg::*;

    localparam int     FRAC       = 16;
    localparam int     TRIG_STEPS = 16;
    localparam longint ONE_Q      = 64'sd1 <<< FRAC;
    localparam longint PI_Q       = (64'sd13493037705 + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
    localparam longint HALF_PI_Q  = PI_Q / 2;
    localparam longint GAIN_Q     = (64'sd2608131496 + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
    localparam longint S32_MAX    = 64'sd2147483647;
    localparam longint S32_MIN    = -64'sd2147483648;
    localparam longint V_LIM      = 64'sd1 <<< 32;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [18:0] hd;
        logic        lim;
        logic        mv;
    } pose_result_t;

    logic [30:0] radius_r, track_r, limit_r, dt_r;
    logic        enable_r;
    longint      px, py, ph;
    pose_result_t pose_q[$];

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint wrap_pi(input longint a);
        longint t;
        t = (a + PI_Q) % (2 * PI_Q);
        if (t < 0)
            t += 2 * PI_Q;
        return t - PI_Q;
    endfunction

    function automatic longint nonzero(input logic [30:0] v);
        return (v == 0) ? 64'sd1 : longint'({33'd0, v});
    endfunction

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic heading_trig(input longint ang, output longint c, output longint s);
        logic   flip;
        longint cx, cy, z, nx, stp;
        flip = 1'b0;
        cx = GAIN_Q;
        cy = 0;
        z = ang;
        if (z > HALF_PI_Q)
        begin
            z -= PI_Q;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q)
        begin
            z += PI_Q;
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_STEPS; i++)
        begin
            stp = (longint'({32'd0, atan_q32(i[4:0])}) + (64'sd1 <<< (31 - FRAC)))
                  >>> (32 - FRAC);
            if (z >= 0)
            begin
                nx = cx - (cy >>> i);
                cy = cy + (cx >>> i);
                z -= stp;
            end
            else
            begin
                nx = cx + (cy >>> i);
                cy = cy - (cx >>> i);
                z += stp;
            end
            cx = nx;
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
    endtask

    task automatic advance_pose(input logic k, input logic [31:0] fa, input logic [31:0] fb);
        longint       a, b2, r, hb, lm, dt, left, right, m, spd, rate, c, s, vx, vy;
        pose_result_t res;
        a = longint'($signed(fa));
        b2 = longint'($signed(fb));
        res.lim = 1'b0;
        res.mv = 1'b0;
        if (enable_r)
        begin
            r = nonzero(radius_r);
            hb = nonzero(track_r);
            lm = nonzero(limit_r);
            dt = longint'({33'd0, dt_r});
            if (!k)
            begin
                left = (a * ONE_Q + b2 * hb) / r;
                right = (a * ONE_Q - b2 * hb) / r;
            end
            else
            begin
                left = a;
                right = b2;
            end
            left = clamp(left, -S32_MAX, S32_MAX);
            right = clamp(right, -S32_MAX, S32_MAX);
            m = mag(left) > mag(right) ? mag(left) : mag(right);
            if (m > lm)
            begin
                left = left * lm / m;
                right = right * lm / m;
                res.lim = 1'b1;
            end
            spd = clamp(r * (left + right) / (ONE_Q * 2), S32_MIN, S32_MAX);
            rate = clamp(r * (left - right) / (2 * hb), S32_MIN, S32_MAX);
            heading_trig(ph, c, s);
            vx = clamp(spd * c / ONE_Q, -V_LIM, V_LIM);
            vy = clamp(spd * s / ONE_Q, -V_LIM, V_LIM);
            px = clamp(px + vx * dt / ONE_Q, S32_MIN, S32_MAX);
            py = clamp(py + vy * dt / ONE_Q, S32_MIN, S32_MAX);
            ph = wrap_pi(ph + rate * dt / ONE_Q);
            res.mv = 1'b1;
        end
        res.x = px[31:0];
        res.y = py[31:0];
        res.hd = ph[18:0];
        pose_q = {pose_q, res};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pose_result_t want;
        if (!rst_n)
        begin
            radius_r = 31'd65536;
            track_r = 31'd65536;
            limit_r = 31'd65536;
            dt_r = 31'd6554;
            enable_r = 1'b0;
            px = 0;
            py = 0;
            ph = 0;
            pose_q.delete();
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WHEEL_RADIUS:  radius_r = cfg_data[30:0];
                    REG_HALF_TRACK:    track_r = cfg_data[30:0];
                    REG_SPEED_LIMIT:   limit_r = cfg_data[30:0];
                    REG_TIME_STEP:     dt_r = cfg_data[30:0];
                    REG_WHEELS_EN:     enable_r = cfg_data[0];
                    REG_START_X:       px = longint'($signed(cfg_data));
                    REG_START_Y:       py = longint'($signed(cfg_data));
                    REG_START_HEADING: ph = wrap_pi(longint'($signed(cfg_data[18:0])));
                    default: ;
                endcase
            end
            if (cmd_valid && !cmd_stall)
                advance_pose(kind, first_value, second_value);
            if (res_valid && !res_stall)
            begin
                if (pose_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual x=%h y=%h",
                             $time, pos_x, pos_y);
                    errors <= errors + 1;
                end
                else
                begin
                    want = pose_q.pop_front();
                    if (want.x !== pos_x || want.y !== pos_y || want.hd !== heading ||
                        want.lim !== speed_limited || want.mv !== moved)
                    begin
                        $display("%0t: pos_x expected %h actual %h", $time, want.x, pos_x);
                        $display("%0t: pos_y expected %h actual %h", $time, want.y, pos_y);
                        $display("%0t: heading expected %h actual %h", $time, want.hd, heading);
                        $display("%0t: speed_limited expected %b actual %b",
                                 $time, want.lim, speed_limited);
                        $display("%0t: moved expected %b actual %b", $time, want.mv, moved);
                        errors <= errors + 1;
                    end
                end
            end
            outstanding <= pose_q.size();
        end
    end

endmodule

[tb/diff_drive_odometry_top_test.sv]
`timescale 1ns / 1ps
// ============================================================================
// diff_drive_odometry_top_test
// Stimulus for the odometry block: directed commands at the field extremes
// and register corner cases, then random phases of commands under random
// geometry, with random idling on both channels and one long result stall.
// ============================================================================
module diff_drive_odometry_top_test;
    import ddo_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic        kind;
    logic [31:0] first_value;
    logic [31:0] second_value;
    logic        res_valid;
    logic        res_stall;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [18:0] heading;
    logic        speed_limited;
    logic        moved;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          errors;
    int          outstanding;
    int          results_seen = 0;
    int          idle_cycles = 0;

    diff_drive_odometry_top uut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .kind(kind),
        .first_value(first_value), .second_value(second_value),
        .res_valid(res_valid), .res_stall(res_stall),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .speed_limited(speed_limited), .moved(moved),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    diff_drive_odometry_checker pose_checker (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .kind(kind),
        .first_value(first_value), .second_value(second_value),
        .res_valid(res_valid), .res_stall(res_stall),
        .pos_x(pos_x), .pos_y(pos_y), .heading(heading),
        .speed_limited(speed_limited), .moved(moved),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .outstanding(outstanding)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (res_valid && !res_stall)
            results_seen <= results_seen + 1;
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_cmd(input logic k, input logic [31:0] a, input logic [31:0] b);
        cmd_valid <= 1'b1;
        kind <= k;
        first_value <= a;
        second_value <= b;
        do @(posedge clk); while (cmd_stall);
    endtask

    task automatic sender_gap();
        int n;
        n = $urandom_range(0, 99);
        if (n < 60)
            return;
        cmd_valid <= 1'b0;
        if (n < 95)
            repeat ($urandom_range(1, 5)) @(posedge clk);
        else
            repeat ($urandom_range(20, 150)) @(posedge clk);
    endtask

    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_geometry(input logic [31:0] r, input logic [31:0] b,
                                 input logic [31:0] lim, input logic [31:0] dt,
                                 input logic [31:0] en, input logic [31:0] sx,
                                 input logic [31:0] sy, input logic [31:0] sh);
        write_reg(REG_WHEEL_RADIUS, r);
        write_reg(REG_HALF_TRACK, b);
        write_reg(REG_SPEED_LIMIT, lim);
        write_reg(REG_TIME_STEP, dt);
        write_reg(REG_WHEELS_EN, en);
        write_reg(REG_START_X, sx);
        write_reg(REG_START_Y, sy);
        write_reg(REG_START_HEADING, sh);
    endtask

    function automatic logic [31:0] rand_speed();
        int n;
        logic [31:0] v;
        n = $urandom_range(0, 99);
        if (n < 5)
            v = 32'h7FFF_FFFF;
        else if (n < 10)
            v = 32'h8000_0000;
        else if (n < 15)
            v = 32'd0;
        else if (n < 35)
            v = $urandom;
        else
        begin
            v = $urandom_range(0, 32'h0004_0000);
            if ($urandom_range(0, 1))
                v = -v;
        end
        return v;
    endfunction

    function automatic logic [31:0] rand_geom();
        int n;
        n = $urandom_range(0, 99);
        if (n < 5)
            return 32'd0;
        if (n < 10)
            return {1'($urandom_range(0, 1)), 31'h7FFF_FFFF};
        if (n < 20)
            return $urandom;
        return {1'($urandom_range(0, 1)), 11'd0, 20'($urandom_range(4096, 20'hFFFFF))};
    endfunction

    function automatic logic [31:0] rand_pos();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'($signed(24'($urandom)));
    endfunction

    initial
    begin
        logic [31:0] dt;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        kind = 1'b0;
        first_value = 32'd0;
        second_value = 32'd0;
        cfg_valid = 1'b0;
        cfg_index = REG_WHEEL_RADIUS;
        cfg_data = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wheels disabled after reset: pose holds
        send_cmd(1'b0, 32'h0001_0000, 32'h0001_0000);
        send_cmd(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        drain();

        load_geometry(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'd6554,
                      32'd1, 32'd0, 32'd0, 32'd0);
        send_cmd(1'b0, 32'd0, 32'd0);
        send_cmd(1'b0, 32'h0000_8000, 32'd0);
        send_cmd(1'b0, 32'd0, 32'h0000_8000);
        send_cmd(1'b1, 32'h0000_8000, 32'h0000_C000);
        send_cmd(1'b1, 32'h0002_0000, 32'hFFFD_0000);
        send_cmd(1'b1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cmd(1'b0, 32'h8000_0000, 32'h8000_0000);
        send_cmd(1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_cmd(1'b0, 32'd0, 32'h8000_0000);
        drain();

        // zero geometry acts as the smallest nonzero value, zero time step, heading wrap on load
        load_geometry(32'd0, 32'd0, 32'd0, 32'd0, 32'd1,
                      32'h7FFF_FFFF, 32'h8000_0000, 32'h0003_FFFF);
        send_cmd(1'b0, 32'h0001_0000, 32'h0001_0000);
        send_cmd(1'b1, 32'hFFFF_FFFF, 32'd1);
        drain();

        load_geometry(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'h7FFF_F000, 32'h8000_1000, 32'h0004_0000);
        send_cmd(1'b0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_cmd(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cmd(1'b1, 32'h8000_0000, 32'h0000_0001);
        drain();

        write_reg(REG_WHEELS_EN, 32'hFFFF_FFFE);
        send_cmd(1'b1, 32'h0001_0000, 32'h0001_0000);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            dt = ($urandom_range(0, 7) == 0) ? rand_geom() : $urandom_range(0, 13107);
            load_geometry(rand_geom(), rand_geom(), rand_geom(), dt,
                          ($urandom_range(0, 9) == 0) ? 32'd0 : ($urandom | 32'd1),
                          rand_pos(), rand_pos(), $urandom);
            for (int i = 0; i < 75; i++)
            begin
                send_cmd(1'($urandom_range(0, 1)), rand_speed(), rand_speed());
                sender_gap();
            end
            drain();
        end

        repeat (100) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        logic held;
        held = 1'b0;
        res_stall = 1'b0;
        @(posedge clk);
        forever
        begin
            res_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(50, 300)) @(posedge clk);
            else
                repeat ($urandom_range(1, 8)) @(posedge clk);
            res_stall <= 1'b1;
            if (!held && results_seen >= 150)
            begin
                held = 1'b1;
                repeat (3000) @(posedge clk);
            end
            else if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(100, 1000)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    end

endmodule

[diff_drive_odometry_top.f]
sv/ddo_pkg.sv
sv/diff_drive_odometry_top.sv
sv/ddo_chk.sv
tb/diff_drive_odometry_checker.sv
tb/diff_drive_odometry_top_test.sv
